// File: rtl/front_coded_rule_decoder_macros.svh
// ----------------------------------------------------------------------------
// front coded rule decoder assertion macros
// shared property forms for the checker, clocked on aclk, held off in reset
// ----------------------------------------------------------------------------
`ifndef FRONT_CODED_RULE_DECODER_MACROS_SVH
`define FRONT_CODED_RULE_DECODER_MACROS_SVH

// condition in the same cycle
`define FCRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition in the following cycle
`define FCRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fcrd_pkg.sv
// ----------------------------------------------------------------------------
// fcrd_pkg
// types and codes shared by the front coded rule decoder files
// ----------------------------------------------------------------------------
package fcrd_pkg;

    // fixed field widths
    localparam int LEN_W    = 7;
    localparam int SYM_IN_W = 16;

    // word kinds on s_tuser
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_SYMBOL = 1'b1;

    // result error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_PREFIX = 2'd1;
    localparam logic [1:0] ERR_LENGTH = 2'd2;
    localparam logic [1:0] ERR_SYMBOL = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUT,
        ST_COPY
    } state_t;

endpackage

// File: rtl/front_coded_rule_decoder.sv
// ----------------------------------------------------------------------------
// front_coded_rule_decoder
// expands a front coded list of grammar rules into a stream of symbols
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake          | contents
//  ---------+-----+--------------------+------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | header (lengths) or one suffix symbol
//  m_       | out | m_tvalid/m_tready  | one decoded symbol or one error word
//
//  a symbol word is accepted in ST_IDLE, then handed over to the output register in ST_PUT
//  a header is accepted, then each prefix symbol is handed over in ST_COPY; the prefix is read
//  back from the rule buffer ram, one read per cycle unless the output stalls, on its single read port
//  a header with error gives one error word through ST_PUT, a header with no prefix gives none
//  m_tready low with an output word pending freezes the copy sequencer and holds the output word
//  aresetn (synchronous) clears lengths, positions and the output valid; the
//  rule buffer is not cleared, only entries already written are ever read
//
module front_coded_rule_decoder #(
    parameter int MAX_RULE_LEN = 64,
    parameter int SYMBOL_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // prefix_length[6:0], suffix_count[13:7], symbol_in[29:14]
    input  logic [0:0]  s_tuser,   // kind[0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // symbol_out[15:0]
    output logic [3:0]  m_tuser,   // rule_first[0], rule_last[1], error[3:2]
    output logic        m_tlast    // last word caused by the input word
);

    // stored symbol width: only the kept low bits of the symbol
    localparam int SymW  = (SYMBOL_BITS < fcrd_pkg::SYM_IN_W) ? SYMBOL_BITS
                                                                 : fcrd_pkg::SYM_IN_W;
    localparam int AddrW = $clog2(MAX_RULE_LEN);
    localparam int LenW  = fcrd_pkg::LEN_W;

    // input fields
    logic                            in_kind;
    logic [LenW-1:0]                 in_prefix;
    logic [LenW-1:0]                 in_suffix;
    logic [SymW-1:0]                 in_sym;

    assign in_kind   = s_tuser[0];
    assign in_prefix = s_tdata[6:0];
    assign in_suffix = s_tdata[13:7];
    assign in_sym    = s_tdata[14 +: SymW];

    // sequencer and rule state
    fcrd_pkg::state_t state_reg, state_next;
    logic [LenW-1:0]  prev_len_reg, prev_len_next;
    logic [LenW-1:0]  wpos_reg, wpos_next;
    logic [LenW-1:0]  sfx_left_reg, sfx_left_next;

    // copy loop
    logic [LenW-1:0]  j_reg, j_next;
    logic [LenW-1:0]  pfx_cnt_reg, pfx_cnt_next;
    logic             sfx_zero_reg, sfx_zero_next;

    // pending single result (symbol word or error)
    logic [15:0]      pend_sym_reg, pend_sym_next;
    logic             pend_first_reg, pend_first_next;
    logic             pend_rlast_reg, pend_rlast_next;
    logic [1:0]       pend_err_reg, pend_err_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic [15:0]      m_sym_reg, m_sym_next;
    logic             m_first_reg, m_first_next;
    logic             m_rlast_reg, m_rlast_next;
    logic [1:0]       m_err_reg, m_err_next;
    logic             m_last_reg, m_last_next;

    // rule buffer ports
    logic             ram_wr_en;
    logic [AddrW-1:0] ram_wr_addr;
    logic [SymW-1:0]  ram_wr_data;
    logic             ram_rd_en;
    logic [AddrW-1:0] ram_rd_addr;
    logic [SymW-1:0]  ram_rd_data;

    // helpers
    logic             s_accept;
    logic             slot_free;
    logic [LenW-1:0]  eff_prev;
    logic [LenW:0]    total;
    logic [LenW-1:0]  j_inc;
    logic             copy_final;
    logic [15:0]      rd_ext;
    logic [15:0]      sym_ext;

    assign s_tready  = (state_reg == fcrd_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;

    // an unfinished rule is cut to what arrived so far
    assign eff_prev   = (sfx_left_reg != '0) ? wpos_reg : prev_len_reg;
    assign total      = {1'b0, in_prefix} + {1'b0, in_suffix};
    assign j_inc      = j_reg + LenW'(1);
    assign copy_final = (j_inc == pfx_cnt_reg);

    always_comb begin
        rd_ext = '0;
        rd_ext[SymW-1:0] = ram_rd_data;
        sym_ext = '0;
        sym_ext[SymW-1:0] = in_sym;
    end

    fcrd_ram #(
        .WIDTH (SymW),
        .DEPTH (MAX_RULE_LEN)
    ) u_buf (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fcrd_pkg::ST_IDLE;
            prev_len_reg <= '0;
            wpos_reg     <= '0;
            sfx_left_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            prev_len_reg <= prev_len_next;
            wpos_reg     <= wpos_next;
            sfx_left_reg <= sfx_left_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        j_reg          <= j_next;
        pfx_cnt_reg    <= pfx_cnt_next;
        sfx_zero_reg   <= sfx_zero_next;
        pend_sym_reg   <= pend_sym_next;
        pend_first_reg <= pend_first_next;
        pend_rlast_reg <= pend_rlast_next;
        pend_err_reg   <= pend_err_next;
        m_sym_reg      <= m_sym_next;
        m_first_reg    <= m_first_next;
        m_rlast_reg    <= m_rlast_next;
        m_err_reg      <= m_err_next;
        m_last_reg     <= m_last_next;
    end

    always_comb begin
        state_next      = state_reg;
        prev_len_next   = prev_len_reg;
        wpos_next       = wpos_reg;
        sfx_left_next   = sfx_left_reg;
        j_next          = j_reg;
        pfx_cnt_next    = pfx_cnt_reg;
        sfx_zero_next   = sfx_zero_reg;
        pend_sym_next   = pend_sym_reg;
        pend_first_next = pend_first_reg;
        pend_rlast_next = pend_rlast_reg;
        pend_err_next   = pend_err_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_sym_next      = m_sym_reg;
        m_first_next    = m_first_reg;
        m_rlast_next    = m_rlast_reg;
        m_err_next      = m_err_reg;
        m_last_next     = m_last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = wpos_reg[AddrW-1:0];
        ram_wr_data     = in_sym;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = '0;

        unique case (state_reg)
            fcrd_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (in_kind == fcrd_pkg::KIND_HEADER) begin
                        // fetch the first prefix symbol right away
                        ram_rd_en      = 1'b1;
                        ram_rd_addr    = '0;
                        prev_len_next  = eff_prev;
                        sfx_left_next  = '0;
                        pend_sym_next  = '0;
                        pend_first_next = 1'b0;
                        pend_rlast_next = 1'b0;
                        if (in_prefix > eff_prev) begin
                            pend_err_next = fcrd_pkg::ERR_PREFIX;
                            state_next    = fcrd_pkg::ST_PUT;
                        end else if (total > (LenW + 1)'(MAX_RULE_LEN)) begin
                            pend_err_next = fcrd_pkg::ERR_LENGTH;
                            state_next    = fcrd_pkg::ST_PUT;
                        end else begin
                            prev_len_next = total[LenW-1:0];
                            wpos_next     = in_prefix;
                            sfx_left_next = in_suffix;
                            j_next        = '0;
                            pfx_cnt_next  = in_prefix;
                            sfx_zero_next = (in_suffix == '0);
                            // no prefix: no result, symbols follow
                            if (in_prefix != '0) begin
                                state_next = fcrd_pkg::ST_COPY;
                            end
                        end
                    end else begin
                        state_next = fcrd_pkg::ST_PUT;
                        if (sfx_left_reg == '0 ||
                            wpos_reg >= LenW'(MAX_RULE_LEN)) begin
                            pend_sym_next   = '0;
                            pend_first_next = 1'b0;
                            pend_rlast_next = 1'b0;
                            pend_err_next   = fcrd_pkg::ERR_SYMBOL;
                        end else begin
                            ram_wr_en       = 1'b1;
                            pend_sym_next   = sym_ext;
                            pend_first_next = (wpos_reg == '0);
                            pend_rlast_next = (sfx_left_reg == LenW'(1));
                            pend_err_next   = fcrd_pkg::ERR_NONE;
                            wpos_next       = wpos_reg + LenW'(1);
                            sfx_left_next   = sfx_left_reg - LenW'(1);
                        end
                    end
                end
            end

            fcrd_pkg::ST_PUT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_sym_next   = pend_sym_reg;
                    m_first_next = pend_first_reg;
                    m_rlast_next = pend_rlast_reg;
                    m_err_next   = pend_err_reg;
                    m_last_next  = 1'b1;
                    state_next   = fcrd_pkg::ST_IDLE;
                end
            end

            fcrd_pkg::ST_COPY: begin
                // ram read data holds symbol j until the word is handed over
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_sym_next   = rd_ext;
                    m_first_next = (j_reg == '0);
                    m_rlast_next = copy_final && sfx_zero_reg;
                    m_err_next   = fcrd_pkg::ERR_NONE;
                    m_last_next  = copy_final;
                    if (copy_final) begin
                        state_next = fcrd_pkg::ST_IDLE;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = j_inc[AddrW-1:0];
                        j_next      = j_inc;
                    end
                end
            end

            default: begin
                state_next = fcrd_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_sym_reg;
    assign m_tuser  = {m_err_reg, m_rlast_reg, m_first_reg};
    assign m_tlast  = m_last_reg;

endmodule

// File: rtl/fcrd_ram.sv
// ----------------------------------------------------------------------------
// fcrd_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module fcrd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/fcrd_checker.sv
// ----------------------------------------------------------------------------
// fcrd_checker
// port level checks of the front coded rule decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "front_coded_rule_decoder_macros.svh"

module fcrd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    logic        out_stall;
    logic [20:0] out_word;
    logic        err_word;
    logic        err_clean;
    logic        sym_accept;
    logic        copy_accept;

    assign out_stall   = m_tvalid && !m_tready;
    assign out_word    = {m_tdata, m_tuser, m_tlast};
    assign err_word    = m_tvalid && (m_tuser[3:2] != fcrd_pkg::ERR_NONE);
    assign err_clean   = (m_tdata == 16'd0) && (m_tuser[1:0] == 2'b00) && m_tlast;
    assign sym_accept  = s_tvalid && s_tready && (s_tuser[0] == fcrd_pkg::KIND_SYMBOL);
    assign copy_accept = s_tvalid && s_tready && (s_tuser[0] == fcrd_pkg::KIND_HEADER)
                         && (s_tdata[6:0] != 7'd0);

    // a stalled output word holds
    `FCRD_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(out_word), "stalled word moved")

    // an error word carries no symbol or rule marks and ends the item
    `FCRD_ASSERT_NOW(a_err_word, err_word, err_clean, "malformed error word")

    // the end of a rule is always the last word of its item
    `FCRD_ASSERT_NOW(a_rule_end, m_tvalid && m_tuser[1], m_tlast, "rule end without tlast")

    // a symbol word always produces exactly one result, so the input closes
    `FCRD_ASSERT_NEXT(a_sym_busy, sym_accept, !s_tready, "input open after a symbol word")

    // a header with a prefix keeps the input closed while it copies
    `FCRD_ASSERT_NEXT(a_hdr_busy, copy_accept, !s_tready, "input open during prefix copy")

endmodule

bind front_coded_rule_decoder fcrd_checker u_fcrd_checker (.*);
